// File: rtl/core/cffsd_pkg.sv
// Shared types and constants for the cyclic first-free server dispatch block.
`timescale 1ns / 1ps

package cffsd_pkg;

    localparam int SERVERS   = 16;
    localparam int SRV_LIMIT = (SERVERS < 16) ? SERVERS : 16;
    localparam int IDX_W     = (SERVERS > 1) ? $clog2(SERVERS) : 1;
    localparam int CFG_W     = 5;
    localparam int TIME_W    = 30;
    localparam int BUSY_W    = 31;
    localparam int COUNT_W   = 20;
    localparam int OUT_IDX_W = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(16);

    localparam logic CMD_DISPATCH = 1'b0;
    localparam logic CMD_REPORT   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DSTART,
        S_DSCAN,
        S_DDONE,
        S_RMAX,
        S_REMIT
    } state_t;

    typedef struct packed {
        logic                 assigned;
        logic [OUT_IDX_W-1:0] server_index;
        logic [COUNT_W-1:0]   served_total;
        logic                 is_report;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic [BUSY_W-1:0]  busy;
        logic [COUNT_W-1:0] count;
    } tbl_wr_t;

endpackage

// File: rtl/core/cffsd_cmp.sv
// Shared magnitude and equality comparator used by the dispatch search and report steps.
`timescale 1ns / 1ps

module cffsd_cmp
    import cffsd_pkg::*;
(
    input  logic [BUSY_W-1:0] a,
    input  logic [BUSY_W-1:0] b,
    output logic              lt,
    output logic              eq
);

    assign lt = (a < b);
    assign eq = (a == b);

endmodule

// File: rtl/core/cffsd_table.sv
// Server table: busy-until times and served counts, one read and one write port.
`timescale 1ns / 1ps

module cffsd_table
    import cffsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [IDX_W-1:0]   rd_idx,
    output logic [BUSY_W-1:0]  rd_busy,
    output logic [COUNT_W-1:0] rd_count,
    input  tbl_wr_t            wr
);

    logic [BUSY_W-1:0]  busy_reg  [SERVERS];
    logic [COUNT_W-1:0] count_reg [SERVERS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SERVERS; i++)
            begin
                busy_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            busy_reg[wr.idx]  <= wr.busy;
            count_reg[wr.idx] <= wr.count;
        end
    end

    assign rd_busy  = busy_reg[rd_idx];
    assign rd_count = count_reg[rd_idx];

endmodule

// File: rtl/core/cffsd_seq.sv
// Sequencer that walks the server table for dispatch searches and reports.
`timescale 1ns / 1ps

module cffsd_seq
    import cffsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [IDX_W-1:0]   cnt_m1,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_cmd,
    input  logic [TIME_W-1:0]  in_arrival,
    input  logic [TIME_W-1:0]  in_duration,
    input  logic               out_space,
    output logic               emit,
    output result_t            res
);

    state_t              state_reg, state_next;
    logic [TIME_W-1:0]   arr_reg, arr_next;
    logic [TIME_W-1:0]   dur_reg, dur_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    start_reg, start_next;
    logic [IDX_W-1:0]    step_reg, step_next;
    logic                found_reg, found_next;
    logic [COUNT_W-1:0]  best_reg, best_next;
    logic [IDX_W-1:0]    lastix_reg, lastix_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;

    logic [BUSY_W-1:0]   rd_busy;
    logic [COUNT_W-1:0]  rd_count;
    logic [COUNT_W-1:0]  count_inc;
    logic [BUSY_W-1:0]   cmp_a, cmp_b;
    logic                cmp_lt, cmp_eq;
    logic                is_free, is_gt;
    logic [IDX_W-1:0]    idx_wrap;
    tbl_wr_t             wr;

    cffsd_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (idx_reg),
        .rd_busy  (rd_busy),
        .rd_count (rd_count),
        .wr       (wr)
    );

    cffsd_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .lt (cmp_lt),
        .eq (cmp_eq)
    );

    // Dispatch states compare busy time to arrival; report states compare counts.
    always_comb
    begin
        if (state_reg inside {S_RMAX, S_REMIT})
        begin
            cmp_a = BUSY_W'(rd_count);
            cmp_b = BUSY_W'(best_reg);
        end
        else
        begin
            cmp_a = rd_busy;
            cmp_b = BUSY_W'(arr_reg);
        end
    end

    assign is_free   = cmp_lt | cmp_eq;
    assign is_gt     = ~cmp_lt & ~cmp_eq;
    assign idx_wrap  = (idx_reg == cnt_m1) ? '0 : idx_reg + 1'b1;
    assign count_inc = (rd_count == COUNT_MAX) ? rd_count : rd_count + 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        arr_next    = arr_reg;
        dur_next    = dur_reg;
        idx_next    = idx_reg;
        start_next  = start_reg;
        step_next   = step_reg;
        found_next  = found_reg;
        best_next   = best_reg;
        lastix_next = lastix_reg;
        pos_next    = pos_reg;
        in_ready    = 1'b0;
        emit        = 1'b0;
        res         = '0;
        wr.en       = 1'b0;
        wr.idx      = idx_reg;
        wr.busy     = BUSY_W'(arr_reg) + BUSY_W'(dur_reg);
        wr.count    = count_inc;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    arr_next = in_arrival;
                    dur_next = in_duration;
                    if (in_cmd == CMD_REPORT)
                    begin
                        best_next   = '0;
                        lastix_next = '0;
                        idx_next    = '0;
                        state_next  = S_RMAX;
                    end
                    else
                    begin
                        idx_next   = pos_reg;
                        state_next = S_DSTART;
                    end
                end
            end
            S_DSTART:
            begin
                // Reduce a stale position modulo the active count.
                if (idx_reg > cnt_m1)
                begin
                    idx_next = idx_reg - cnt_m1 - 1'b1;
                end
                else
                begin
                    start_next = idx_reg;
                    step_next  = '0;
                    state_next = S_DSCAN;
                end
            end
            S_DSCAN:
            begin
                if (is_free)
                begin
                    found_next = 1'b1;
                    state_next = S_DDONE;
                end
                else if (step_reg == cnt_m1)
                begin
                    found_next = 1'b0;
                    state_next = S_DDONE;
                end
                else
                begin
                    idx_next  = idx_wrap;
                    step_next = step_reg + 1'b1;
                end
            end
            S_DDONE:
            begin
                if (out_space)
                begin
                    emit             = 1'b1;
                    res.assigned     = found_reg;
                    res.server_index = found_reg ? OUT_IDX_W'(idx_reg) : '0;
                    res.served_total = found_reg ? count_inc : '0;
                    res.is_report    = 1'b0;
                    res.last         = 1'b1;
                    wr.en            = found_reg;
                    pos_next         = (start_reg == cnt_m1) ? '0 : start_reg + 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_RMAX:
            begin
                if (is_gt)
                begin
                    best_next   = rd_count;
                    lastix_next = idx_reg;
                end
                else if (cmp_eq)
                begin
                    lastix_next = idx_reg;
                end
                if (idx_reg == cnt_m1)
                begin
                    idx_next   = '0;
                    state_next = S_REMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_REMIT:
            begin
                if (cmp_eq)
                begin
                    if (out_space)
                    begin
                        emit             = 1'b1;
                        res.assigned     = 1'b1;
                        res.server_index = OUT_IDX_W'(idx_reg);
                        res.served_total = best_reg;
                        res.is_report    = 1'b1;
                        res.last         = (idx_reg == lastix_reg);
                        if (idx_reg == lastix_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pos_reg    <= '0;
            idx_reg    <= '0;
            start_reg  <= '0;
            step_reg   <= '0;
            found_reg  <= 1'b0;
            best_reg   <= '0;
            lastix_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            idx_reg    <= idx_next;
            start_reg  <= start_next;
            step_reg   <= step_next;
            found_reg  <= found_next;
            best_reg   <= best_next;
            lastix_reg <= lastix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        arr_reg <= arr_next;
        dur_reg <= dur_next;
    end

    // The table is only updated at the end of a successful search.
    a_wr_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == S_DDONE && found_reg))
        else $error("table write outside a successful dispatch");

    // The search walk never leaves the active part of the ring.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DSCAN) |-> (idx_reg <= cnt_m1 && step_reg <= cnt_m1))
        else $error("dispatch walk beyond active servers");

    // The flagged final report beat ends the report.
    a_report_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && res.is_report && res.last) |=> (state_reg == S_IDLE))
        else $error("report continued after its last beat");

    // The report emit walk cannot run past the last busiest server.
    a_remit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REMIT) |-> (idx_reg <= lastix_reg))
        else $error("report walk passed the last busiest server");

endmodule

// File: rtl/core/cyclic_first_free_server_dispatch.sv
// Top level of the cyclic first-free server dispatch block.
// Dispatch steps: after acceptance a dispatch passes a start state that folds a stale position
// into range, a search over the servers in use and a write-back state.
// Flow: one input at a time, each finished before the next is taken; a report waits out output
// stalls and sends one beat per busiest server.
// Reset: rst_n clears busy times, counts and job position, sets 16 servers, empties the output.
`timescale 1ns / 1ps

module cyclic_first_free_server_dispatch
    import cffsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: server_count.
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [29:0] arrival_time, [59:30] duration, rest zero
    input  logic        s_axis_tuser,  // [0] command
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [0] assigned, [4:1] server_index,
                                       // [24:5] served_total, rest zero
    output logic        m_axis_tuser,  // [0] is_report
    output logic        m_axis_tlast   // last beat of this input
);

    logic [CFG_W-1:0] cfg_reg;
    logic [CFG_W-1:0] cnt_eff;
    logic [IDX_W-1:0] cnt_m1;
    logic             out_valid_reg;
    result_t          out_reg;
    logic             out_space;
    logic             emit;
    result_t          res;

    // The server count register is written directly; no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_wdata;
        end
    end

    // Zero acts as one server and anything above the built count is clamped to it.
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            cnt_eff = CFG_W'(1);
        end
        else if (cfg_reg > CFG_W'(SRV_LIMIT))
        begin
            cnt_eff = CFG_W'(SRV_LIMIT);
        end
        else
        begin
            cnt_eff = cfg_reg;
        end
    end

    assign cnt_m1 = IDX_W'(cnt_eff - 1'b1);

    // The sequencer may hand over a result whenever the output register is free
    // or is being drained in this same cycle.
    assign out_space = ~out_valid_reg | m_axis_tready;

    cffsd_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cnt_m1      (cnt_m1),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_cmd      (s_axis_tuser),
        .in_arrival  (s_axis_tdata[29:0]),
        .in_duration (s_axis_tdata[59:30]),
        .out_space   (out_space),
        .emit        (emit),
        .res         (res)
    );

    // Output register separating the sequencer from the downstream stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_reg.served_total, out_reg.server_index,
                            out_reg.assigned};
    assign m_axis_tuser  = out_reg.is_report;
    assign m_axis_tlast  = out_reg.last;

endmodule

// File: tb/cffsd_checker.sv
// Checker that predicts and compares the dispatch block's output beats.
`timescale 1ns / 1ps

module cffsd_checker
    import cffsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [63:0] in_data,
    input  logic        in_user,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] out_data,
    input  logic        out_user,
    input  logic        out_last,
    output int          mismatches,
    output int          pending
);

    localparam int PRINT_CAP = 60;

    // Shadow copy of the server table, the job position and the server count.
    logic [BUSY_W-1:0]  busy_until [SERVERS];
    logic [COUNT_W-1:0] jobs_served [SERVERS];
    int                 job_pos;
    logic [CFG_W-1:0]   count_reg;

    // Beats the block still owes, oldest first.
    result_t owed_beats [$];

    initial
    begin
        mismatches = 0;
        pending    = 0;
    end

    function automatic int servers_active();
        int c;
        c = count_reg;
        if (c < 1)
            c = 1;
        if (c > SRV_LIMIT)
            c = SRV_LIMIT;
        return c;
    endfunction

    // Applies one accepted input beat to the shadow table and queues the beats it causes.
    task automatic dispatch_or_report(input logic cmd, input logic [TIME_W-1:0] arrival,
                                      input logic [TIME_W-1:0] span);
        int                 n;
        int                 start;
        int                 s;
        int                 pick;
        int                 last_busiest;
        logic [COUNT_W-1:0] peak;
        result_t            r;
        n = servers_active();
        if (cmd == CMD_DISPATCH)
        begin
            start = job_pos % n;
            pick  = -1;
            for (int i = 0; i < n; i++)
            begin
                s = (start + i) % n;
                if (pick < 0 && busy_until[s] <= BUSY_W'(arrival))
                    pick = s;
            end
            r      = '0;
            r.last = 1'b1;
            if (pick >= 0)
            begin
                busy_until[pick] = BUSY_W'(arrival) + BUSY_W'(span);
                if (jobs_served[pick] != COUNT_MAX)
                    jobs_served[pick] = jobs_served[pick] + 1'b1;
                r.assigned     = 1'b1;
                r.server_index = OUT_IDX_W'(pick);
                r.served_total = jobs_served[pick];
            end
            owed_beats = {owed_beats, r};
            job_pos = (start + 1) % n;
        end
        else
        begin
            peak = '0;
            for (int i = 0; i < n; i++)
                if (jobs_served[i] > peak)
                    peak = jobs_served[i];
            last_busiest = 0;
            for (int i = 0; i < n; i++)
                if (jobs_served[i] == peak)
                    last_busiest = i;
            for (int i = 0; i < n; i++)
            begin
                if (jobs_served[i] == peak)
                begin
                    r              = '0;
                    r.assigned     = 1'b1;
                    r.server_index = OUT_IDX_W'(i);
                    r.served_total = peak;
                    r.is_report    = 1'b1;
                    r.last         = (i == last_busiest);
                    owed_beats = {owed_beats, r};
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < PRINT_CAP)
            $display("%0t ns: mismatch in %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SERVERS; i++)
            begin
                busy_until[i]  = '0;
                jobs_served[i] = '0;
            end
            job_pos   = 0;
            count_reg = CFG_RESET;
            owed_beats.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                count_reg = cfg_wdata;
            if (in_valid && in_ready)
                dispatch_or_report(in_user, in_data[TIME_W-1:0], in_data[2*TIME_W-1:TIME_W]);
            if (out_valid && out_ready)
            begin
                got.assigned     = out_data[0];
                got.server_index = out_data[4:1];
                got.served_total = out_data[24:5];
                got.is_report    = out_user;
                got.last         = out_last;
                if (owed_beats.size() == 0)
                    report_mismatch("beat with none pending", got, 0);
                else
                begin
                    want = owed_beats.pop_front();
                    if (got.assigned != want.assigned)
                        report_mismatch("assigned", got.assigned, want.assigned);
                    if (got.server_index != want.server_index)
                        report_mismatch("server_index", got.server_index, want.server_index);
                    if (got.served_total != want.served_total)
                        report_mismatch("served_total", got.served_total, want.served_total);
                    if (got.is_report != want.is_report)
                        report_mismatch("is_report", got.is_report, want.is_report);
                    if (got.last != want.last)
                        report_mismatch("last", got.last, want.last);
                end
            end
            pending <= owed_beats.size();
        end
    end

endmodule

// File: tb/cyclic_first_free_server_dispatch_tb.sv
// Testbench top: stimulus, flow control and verdict for the server dispatch block.
`timescale 1ns / 1ps

module cyclic_first_free_server_dispatch_tb
    import cffsd_pkg::*;
();

    // Cycles to let pass once nothing is pending, enough for the longest
    // search plus write-back, so the block is idle before the count changes.
    localparam int IDLE_CYCLES  = 64;
    // Generous ceiling: every beat stalled by the slowest receiver mode,
    // every report listing all sixteen servers, plus the long hold-off.
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_BEATS  = 56;
    localparam int NUM_PHASES   = 7;
    localparam logic [TIME_W-1:0] TIME_TOP = {TIME_W{1'b1}};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // [29:0] arrival_time, [59:30] duration, rest zero
    logic        s_axis_tuser = 1'b0; // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [0] assigned, [4:1] server_index, [24:5] served_total
    logic        m_axis_tuser;        // [0] is_report
    logic        m_axis_tlast;

    int mismatches;
    int pending;
    int cycle_count = 0;
    int burst_left = 0;
    int now_t = 200;
    bit hold_req = 1'b0;

    // Server count settings, one per random phase. The zero and all-ones
    // writes exercise the clamping; dropping from 16 to 1 leaves a stale
    // job position that must be folded back into range.
    int phase_count [NUM_PHASES] = '{1, 5, 16, 0, 31, 3, 16};

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    cyclic_first_free_server_dispatch dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    cffsd_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_user    (s_axis_tuser),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_user   (m_axis_tuser),
        .out_last   (m_axis_tlast),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Offers one beat and returns at the edge where it is taken. Beats come
    // in bursts; at the end of a burst valid drops for a random gap. Within a
    // burst valid stays high, so it is never lowered and raised in one step.
    task automatic send_beat(input logic cmd, input logic [TIME_W-1:0] arrival,
                             input logic [TIME_W-1:0] span);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, span, arrival};
        s_axis_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            // Mostly short bursts, now and then a long run with no gaps.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Waits until every owed beat has arrived, then lets the block settle.
    // The first edge lets the pending count catch up with the last beat taken.
    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_server_count(input logic [4:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Jobs arrive on a slowly advancing time base so that servers keep
    // freeing up; durations are scaled to the ring size so that some phases
    // run near capacity and drop jobs. A minority are reports with random
    // payload, late arrivals from the past, zero durations and idle jumps.
    task automatic random_phase(input int beats, input int ring);
        int roll;
        int arrival;
        int span;
        for (int k = 0; k < beats; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 12)
                send_beat(CMD_REPORT, TIME_W'($urandom), TIME_W'($urandom));
            else
            begin
                if (roll < 17)
                    arrival = (now_t > 60) ? now_t - $urandom_range(0, 60) : 0;
                else
                begin
                    now_t   = now_t + (roll < 20 ? $urandom_range(50, 150)
                                                 : $urandom_range(0, 3));
                    arrival = now_t;
                end
                span = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6 * ring + 6);
                send_beat(CMD_DISPATCH, TIME_W'(arrival), TIME_W'(span));
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // The receiver switches among always ready, random stalls and heavy
    // stalls. Once asked, it holds ready low for a long counted stretch so
    // the output register and then the input side back up.
    initial
    begin
        int  mode;
        int  mode_left;
        int  hold_left;
        bit  hold_done;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= $urandom_range(0, 1);
                    default: m_axis_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Hard stop in case the block hangs or a beat never comes.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int ring;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the reset count of 16 servers.
        // A report on a fresh table lists every server, all with count zero.
        send_beat(CMD_REPORT, '0, '0);
        // With the table free at time zero, job k lands on server k. Server 0
        // gets a zero duration and stays free at its own arrival time.
        send_beat(CMD_DISPATCH, '0, '0);
        for (int k = 1; k < 12; k++)
            send_beat(CMD_DISPATCH, '0, TIME_W'(10 * k));
        // Servers 12 to 14 take the field extremes and stay busy for good;
        // server 15 stays busy until time 1.
        send_beat(CMD_DISPATCH, '0, TIME_TOP);
        send_beat(CMD_DISPATCH, TIME_TOP, TIME_TOP);
        send_beat(CMD_DISPATCH, TIME_TOP, '0);
        send_beat(CMD_DISPATCH, '0, 30'd1);
        // Position wraps to 0; server 0 is free again and counts twice.
        send_beat(CMD_DISPATCH, '0, 30'd7);
        // Every server is now busy past time zero, so this job is dropped.
        send_beat(CMD_DISPATCH, '0, 30'd3);
        // A single busiest server is reported with last set.
        send_beat(CMD_REPORT, TIME_TOP, TIME_TOP);
        // The search wraps past the busy servers and lands on the top one.
        send_beat(CMD_DISPATCH, 30'd10, 30'd5);
        // Two servers tie for the maximum; last marks the higher index.
        send_beat(CMD_REPORT, '0, '0);
        s_axis_tvalid <= 1'b0;
        drain();

        // Random phases, each under its own server count. The count changes
        // only once the block has delivered everything and gone idle.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_server_count(5'(phase_count[p]));
            ring = (phase_count[p] == 0) ? 1 : (phase_count[p] > 16 ? 16 : phase_count[p]);
            if (p == 1)
                hold_req = 1'b1;
            random_phase(PHASE_BEATS, ring);
            drain();
        end

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
